// ----- rtl/ptk_pkg.sv -----
// ----------------------------------------------------------------------------
// ptk_pkg
// Shared sizes, codes and memory word layouts of the peer token bucket and
// key interval limiter.
// ----------------------------------------------------------------------------
package ptk_pkg;

  localparam int PEER_SLOTS          = 256;
  localparam int KEY_ENTRIES         = 64;
  localparam int PAIR_ENTRIES        = 64;
  localparam int TOKEN_FRACTION_BITS = 16;

  localparam int PEER_AW = $clog2(PEER_SLOTS);
  localparam int KEY_AW  = $clog2(KEY_ENTRIES);
  localparam int PAIR_AW = $clog2(PAIR_ENTRIES);

  // bucket level: 8 integer bits over the fraction
  localparam int LVL_W = 8 + TOKEN_FRACTION_BITS;
  // refill dividend: elapsed seconds shifted up by the fraction
  localparam int DVD_W = 32 + TOKEN_FRACTION_BITS;

  localparam int SCAN_N  = (KEY_ENTRIES > PAIR_ENTRIES) ? KEY_ENTRIES : PAIR_ENTRIES;
  localparam int PRUNE_N = (PEER_SLOTS > SCAN_N) ? PEER_SLOTS : SCAN_N;
  localparam int WALK_W  = $clog2(PRUNE_N + 1);

  localparam int CFG_AW = 5;

  typedef enum logic [1:0] {
    FUNC_FULL    = 2'd0,
    FUNC_CONSUME = 2'd1,
    FUNC_CHECK   = 2'd2,
    FUNC_COMMIT  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    VERD_OK     = 2'd0,
    VERD_EMPTY  = 2'd1,
    VERD_GLOBAL = 2'd2,
    VERD_PAIR   = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    REG_PERIOD = 3'd0,
    REG_BURST  = 3'd1,
    REG_GMIN   = 3'd2,
    REG_PMIN   = 3'd3,
    REG_PIDLE  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [31:0]      stamp;
  } bkt_word_t;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] middle;
    logic [31:0] lower;
    logic [31:0] stamp;
  } gkey_word_t;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] middle;
    logic [39:0] lower_peer;
    logic [31:0] stamp;
  } pkey_word_t;

endpackage

// ----- rtl/ptk_if.sv -----
// ----------------------------------------------------------------------------
// ptk channel interfaces
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptk_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  peer_slot;
  logic [63:0] key_high;
  logic [63:0] key_middle;
  logic [31:0] key_low;
  logic [31:0] now_seconds;

  modport source (output valid, func, peer_slot, key_high, key_middle, key_low,
                  now_seconds, input ready);
  modport sink (input valid, func, peer_slot, key_high, key_middle, key_low,
                now_seconds, output ready);
endinterface

interface ptk_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       passed;
  logic       table_full;

  modport source (output valid, verdict, passed, table_full, input ready);
  modport sink (input valid, verdict, passed, table_full, output ready);
endinterface

// ----- rtl/ptk_ram.sv -----
// ----------------------------------------------------------------------------
// ptk_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ptk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ptk_div.sv -----
// ----------------------------------------------------------------------------
// ptk_div
// Restoring divider for the refill amount, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptk_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [ptk_pkg::DVD_W-1:0] dividend,
  input  logic [15:0]             divisor,
  output logic                    done,
  output logic [ptk_pkg::DVD_W-1:0] quo
);

  localparam int CNT_W = $clog2(ptk_pkg::DVD_W + 1);

  logic [ptk_pkg::DVD_W-1:0] quo_r;
  logic [15:0]               rem_r;
  logic [15:0]               dsr_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [16:0]               shifted;
  logic                      ge;
  logic [15:0]               rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[ptk_pkg::DVD_W-1]};
    ge      = shifted >= {1'b0, dsr_r};
    rem_nxt = ge ? 16'(shifted - {1'b0, dsr_r}) : shifted[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
        cnt_r  <= CNT_W'(ptk_pkg::DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[ptk_pkg::DVD_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/peer_token_bucket_key_limiter.sv -----
// ----------------------------------------------------------------------------
// peer_token_bucket_key_limiter
// Per-peer token bucket with per-key and per-key-and-peer minimum intervals.
// ----------------------------------------------------------------------------
// One item at a time. Check and commit items walk both key tables at one
// entry per cycle. Bucket items may also run the 48-step refill divider. A
// due prune first walks the bucket memory and both key tables together.
// Reset clears the valid bits of all three memories at once; there is no
// clearing pass. The result is registered in the final step.
module peer_token_bucket_key_limiter (
  input  logic                        clk,
  input  logic                        rst_n,
  ptk_in_if.sink                      in_ch,
  ptk_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ptk_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int F = ptk_pkg::TOKEN_FRACTION_BITS;
  localparam int LW = ptk_pkg::LVL_W;
  localparam int WW = ptk_pkg::WALK_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PCHK, S_PRUNE, S_BRD, S_BUPD, S_DIV, S_BDEC, S_SCAN, S_KEY, S_FIN
  } state_t;

  // configuration
  logic [15:0] period_r;
  logic [7:0]  burst_r;
  logic [19:0] gmin_r;
  logic [19:0] pmin_r;
  logic [19:0] pidle_r;

  // request
  state_t           state_r;
  ptk_pkg::func_t   func_r;
  logic [7:0]       peer_r;
  logic [63:0]      khi_r;
  logic [63:0]      kmid_r;
  logic [31:0]      klo_r;
  logic [31:0]      now_r;
  logic [31:0]      last_prune_r;

  // walk pipeline
  logic [WW-1:0]    walk_r;
  logic             chk_v_r;
  logic [WW-1:0]    chk_i_r;

  logic [LW-1:0]    lvl_r;
  logic [31:0]      stamp_r;

  logic                       g_hit_r, g_free_r, p_hit_r, p_free_r;
  logic [ptk_pkg::KEY_AW-1:0]  g_idx_r, g_fidx_r;
  logic [ptk_pkg::PAIR_AW-1:0] p_idx_r, p_fidx_r;
  logic [31:0]                g_time_r, p_time_r;

  logic [ptk_pkg::PEER_SLOTS-1:0]   bvalid_r;
  logic [ptk_pkg::KEY_ENTRIES-1:0]  gvalid_r;
  logic [ptk_pkg::PAIR_ENTRIES-1:0] pvalid_r;

  ptk_pkg::verdict_t res_verdict_r;
  logic              res_passed_r, res_full_r;
  logic              out_valid_r;
  logic [1:0]        out_verdict_r;
  logic              out_passed_r, out_full_r;

  // memory ports
  logic                        b_we;
  logic [ptk_pkg::PEER_AW-1:0] b_raddr;
  ptk_pkg::bkt_word_t          b_wdata, b_rdata;
  logic                        g_we;
  logic [ptk_pkg::KEY_AW-1:0]  g_waddr;
  ptk_pkg::gkey_word_t         g_wdata, g_rdata;
  logic                        p_we;
  logic [ptk_pkg::PAIR_AW-1:0] p_waddr;
  ptk_pkg::pkey_word_t         p_wdata, p_rdata;

  logic [ptk_pkg::PEER_AW-1:0] slot;
  logic [LW-1:0]               cap, one;
  logic [WW-1:0]               walk_lim;
  logic [31:0]                 cur_t;
  logic                        div_start, div_done;
  logic [ptk_pkg::DVD_W-1:0]   div_quo;
  logic [ptk_pkg::DVD_W:0]     refill_sum;
  logic                        g_soon, p_soon;
  ptk_pkg::verdict_t           kverd;
  logic                        commit_c, full_c;
  logic                        g_match, p_match;
  logic [ptk_pkg::KEY_AW-1:0]  gi;
  logic [ptk_pkg::PAIR_AW-1:0] pi;
  logic [ptk_pkg::PEER_AW-1:0] bi;

  function automatic logic is_idle(input logic [31:0] now, input logic [31:0] t,
                                   input logic [19:0] idle);
    logic [31:0] age;
    age = now - t;
    return (now > t) && (age > 32'(idle));
  endfunction

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd60;
      burst_r  <= 8'd10;
      gmin_r   <= 20'd3600;
      pmin_r   <= 20'd600;
      pidle_r  <= 20'd3600;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[4:2])
        ptk_pkg::REG_PERIOD: period_r <= cfg_pwdata[15:0];
        ptk_pkg::REG_BURST:  burst_r  <= cfg_pwdata[7:0];
        ptk_pkg::REG_GMIN:   gmin_r   <= cfg_pwdata[19:0];
        ptk_pkg::REG_PMIN:   pmin_r   <= cfg_pwdata[19:0];
        ptk_pkg::REG_PIDLE:  pidle_r  <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      ptk_pkg::REG_PERIOD: cfg_prdata = 32'(period_r);
      ptk_pkg::REG_BURST:  cfg_prdata = 32'(burst_r);
      ptk_pkg::REG_GMIN:   cfg_prdata = 32'(gmin_r);
      ptk_pkg::REG_PMIN:   cfg_prdata = 32'(pmin_r);
      ptk_pkg::REG_PIDLE:  cfg_prdata = 32'(pidle_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // memories and divider
  // --------------------------------------------------------------------------
  ptk_ram #(.WIDTH($bits(ptk_pkg::bkt_word_t)), .DEPTH(ptk_pkg::PEER_SLOTS)) u_bkt_ram (
    .clk(clk), .we(b_we), .waddr(slot), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata)
  );

  ptk_ram #(.WIDTH($bits(ptk_pkg::gkey_word_t)), .DEPTH(ptk_pkg::KEY_ENTRIES)) u_gkey_ram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(walk_r[ptk_pkg::KEY_AW-1:0]), .rdata(g_rdata)
  );

  ptk_ram #(.WIDTH($bits(ptk_pkg::pkey_word_t)), .DEPTH(ptk_pkg::PAIR_ENTRIES)) u_pkey_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(walk_r[ptk_pkg::PAIR_AW-1:0]), .rdata(p_rdata)
  );

  ptk_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend({now_r - cur_t, F'(0)}),
    .divisor((period_r == 16'd0) ? 16'd1 : period_r),
    .done(div_done), .quo(div_quo)
  );

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  always_comb begin
    slot     = ptk_pkg::PEER_AW'(peer_r % ptk_pkg::PEER_SLOTS);
    cap      = {burst_r, F'(0)};
    one      = LW'(1) << F;
    walk_lim = (state_r == S_PRUNE) ? WW'(ptk_pkg::PRUNE_N) : WW'(ptk_pkg::SCAN_N);
    b_raddr  = (state_r == S_PRUNE) ? walk_r[ptk_pkg::PEER_AW-1:0] : slot;
    cur_t    = bvalid_r[slot] ? b_rdata.stamp : 32'd0;
    div_start = (state_r == S_BUPD) && (cur_t != 32'd0) && (now_r > cur_t);
    refill_sum = (ptk_pkg::DVD_W+1)'(lvl_r) + (ptk_pkg::DVD_W+1)'(div_quo);

    gi = chk_i_r[ptk_pkg::KEY_AW-1:0];
    pi = chk_i_r[ptk_pkg::PAIR_AW-1:0];
    bi = chk_i_r[ptk_pkg::PEER_AW-1:0];
    g_match = (g_rdata.upper == khi_r) && (g_rdata.middle == kmid_r) &&
              (g_rdata.lower == klo_r);
    p_match = (p_rdata.upper == khi_r) && (p_rdata.middle == kmid_r) &&
              (p_rdata.lower_peer == {peer_r, klo_r});

    g_soon = g_hit_r && ({1'b0, now_r} < ({1'b0, g_time_r} + 33'(gmin_r)));
    p_soon = p_hit_r && ({1'b0, now_r} < ({1'b0, p_time_r} + 33'(pmin_r)));
    kverd  = g_soon ? ptk_pkg::VERD_GLOBAL : (p_soon ? ptk_pkg::VERD_PAIR : ptk_pkg::VERD_OK);
    commit_c = (func_r == ptk_pkg::FUNC_COMMIT) ||
               ((func_r == ptk_pkg::FUNC_FULL) && (kverd == ptk_pkg::VERD_OK));
    full_c   = commit_c && (!(g_hit_r || g_free_r) || !(p_hit_r || p_free_r));

    // bucket write back
    b_we    = 1'b0;
    b_wdata = '{level: lvl_r, stamp: stamp_r};
    if (state_r == S_BDEC) begin
      if (lvl_r < one) begin
        b_we = 1'b1;
      end else if (func_r == ptk_pkg::FUNC_CONSUME) begin
        b_we = 1'b1;
        b_wdata.level = lvl_r - one;
      end
    end else if (state_r == S_KEY && func_r == ptk_pkg::FUNC_FULL) begin
      b_we = 1'b1;
      if (kverd == ptk_pkg::VERD_OK) begin
        b_wdata.level = lvl_r - one;
      end
    end

    // key commit: update the match, else take the lowest free entry
    g_we    = (state_r == S_KEY) && commit_c && (g_hit_r || g_free_r);
    g_waddr = g_hit_r ? g_idx_r : g_fidx_r;
    g_wdata = '{upper: khi_r, middle: kmid_r, lower: klo_r, stamp: now_r};
    p_we    = (state_r == S_KEY) && commit_c && (p_hit_r || p_free_r);
    p_waddr = p_hit_r ? p_idx_r : p_fidx_r;
    p_wdata = '{upper: khi_r, middle: kmid_r, lower_peer: {peer_r, klo_r}, stamp: now_r};
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_prune_r <= '0;
      bvalid_r     <= '0;
      gvalid_r     <= '0;
      pvalid_r     <= '0;
      out_valid_r  <= 1'b0;
      chk_v_r      <= 1'b0;
      walk_r       <= '0;
    end else begin
      // the final step reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      if (b_we) begin
        bvalid_r[slot] <= (b_wdata.stamp != 32'd0);
      end
      if (g_we) begin
        gvalid_r[g_waddr] <= 1'b1;
      end
      if (p_we) begin
        pvalid_r[p_waddr] <= 1'b1;
      end

      // shared walk over memory entries: issue a read, check it next cycle
      if (state_r == S_PRUNE || state_r == S_SCAN) begin
        if (walk_r < walk_lim) begin
          walk_r  <= walk_r + 1'b1;
          chk_v_r <= 1'b1;
          chk_i_r <= walk_r;
        end else begin
          chk_v_r <= 1'b0;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r <= ptk_pkg::func_t'(in_ch.func);
            peer_r <= in_ch.peer_slot;
            khi_r  <= in_ch.key_high;
            kmid_r <= in_ch.key_middle;
            klo_r  <= in_ch.key_low;
            now_r  <= in_ch.now_seconds;
            walk_r <= '0;
            chk_v_r <= 1'b0;
            g_hit_r <= 1'b0; g_free_r <= 1'b0;
            p_hit_r <= 1'b0; p_free_r <= 1'b0;
            if (in_ch.func == ptk_pkg::FUNC_FULL || in_ch.func == ptk_pkg::FUNC_CONSUME) begin
              state_r <= S_PCHK;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_PCHK: begin
          if ({1'b0, now_r} >= ({1'b0, last_prune_r} + 33'(pidle_r))) begin
            last_prune_r <= now_r;
            state_r      <= S_PRUNE;
          end else begin
            state_r <= S_BRD;
          end
        end
        S_PRUNE: begin
          if (chk_v_r) begin
            if (chk_i_r < WW'(ptk_pkg::PEER_SLOTS) && bvalid_r[bi] &&
                is_idle(now_r, b_rdata.stamp, pidle_r)) begin
              bvalid_r[bi] <= 1'b0;
            end
            if (chk_i_r < WW'(ptk_pkg::KEY_ENTRIES) && gvalid_r[gi] &&
                is_idle(now_r, g_rdata.stamp, pidle_r)) begin
              gvalid_r[gi] <= 1'b0;
            end
            if (chk_i_r < WW'(ptk_pkg::PAIR_ENTRIES) && pvalid_r[pi] &&
                is_idle(now_r, p_rdata.stamp, pidle_r)) begin
              pvalid_r[pi] <= 1'b0;
            end
          end else if (walk_r == walk_lim) begin
            walk_r  <= '0;
            state_r <= S_BRD;
          end
        end
        S_BRD: begin
          state_r <= S_BUPD;
        end
        S_BUPD: begin
          if (cur_t == 32'd0) begin
            lvl_r   <= cap;
            stamp_r <= now_r;
            state_r <= S_BDEC;
          end else if (now_r <= cur_t) begin
            lvl_r   <= b_rdata.level;
            stamp_r <= cur_t;
            state_r <= S_BDEC;
          end else begin
            lvl_r   <= b_rdata.level;
            stamp_r <= now_r;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            lvl_r   <= (refill_sum < (ptk_pkg::DVD_W+1)'(cap)) ? refill_sum[LW-1:0] : cap;
            state_r <= S_BDEC;
          end
        end
        S_BDEC: begin
          if (lvl_r < one) begin
            res_verdict_r <= ptk_pkg::VERD_EMPTY;
            res_passed_r  <= 1'b0;
            res_full_r    <= 1'b0;
            state_r       <= S_FIN;
          end else if (func_r == ptk_pkg::FUNC_CONSUME) begin
            res_verdict_r <= ptk_pkg::VERD_OK;
            res_passed_r  <= 1'b1;
            res_full_r    <= 1'b0;
            state_r       <= S_FIN;
          end else begin
            walk_r  <= '0;
            chk_v_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chk_v_r) begin
            if (chk_i_r < WW'(ptk_pkg::KEY_ENTRIES)) begin
              if (gvalid_r[gi]) begin
                if (!g_hit_r && g_match) begin
                  g_hit_r  <= 1'b1;
                  g_idx_r  <= gi;
                  g_time_r <= g_rdata.stamp;
                end
              end else if (!g_free_r) begin
                g_free_r <= 1'b1;
                g_fidx_r <= gi;
              end
            end
            if (chk_i_r < WW'(ptk_pkg::PAIR_ENTRIES)) begin
              if (pvalid_r[pi]) begin
                if (!p_hit_r && p_match) begin
                  p_hit_r  <= 1'b1;
                  p_idx_r  <= pi;
                  p_time_r <= p_rdata.stamp;
                end
              end else if (!p_free_r) begin
                p_free_r <= 1'b1;
                p_fidx_r <= pi;
              end
            end
          end else if (walk_r == walk_lim) begin
            state_r <= S_KEY;
          end
        end
        S_KEY: begin
          case (func_r)
            ptk_pkg::FUNC_COMMIT: begin
              res_verdict_r <= ptk_pkg::VERD_OK;
              res_passed_r  <= !full_c;
              res_full_r    <= full_c;
            end
            ptk_pkg::FUNC_CHECK: begin
              res_verdict_r <= kverd;
              res_passed_r  <= (kverd == ptk_pkg::VERD_OK);
              res_full_r    <= 1'b0;
            end
            default: begin
              res_verdict_r <= kverd;
              res_passed_r  <= (kverd == ptk_pkg::VERD_OK);
              res_full_r    <= full_c;
            end
          endcase
          state_r <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_verdict_r <= res_verdict_r;
            out_passed_r  <= res_passed_r;
            out_full_r    <= res_full_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.verdict    = out_verdict_r;
  assign out_ch.passed     = out_passed_r;
  assign out_ch.table_full = out_full_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_prune_no_bucket_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRUNE) |-> !b_we)
    else $error("bucket written during prune walk");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside refill step");

  a_key_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (g_we || p_we) |-> ((state_r == S_KEY) && commit_c))
    else $error("key table written outside commit");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside final step");

endmodule
